// ===== hdl/lrcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrcs_pkg
// Shared types, widths and codes of the lidar range cluster segmenter.
// ----------------------------------------------------------------------------
package lrcs_pkg;

  // Samples per scan; later samples are invalid until end of scan.
  localparam int SCAN_POINTS = 512;

  // Sample index and run count must hold SCAN_POINTS itself.
  localparam int IDX_W   = $clog2(SCAN_POINTS + 1);
  // Largest index sum of one run: 0 + 1 + ... + (SCAN_POINTS - 1).
  localparam int SUM_W   = $clog2(SCAN_POINTS * (SCAN_POINTS - 1) / 2 + 1);
  localparam int STEP_W  = 7;
  localparam int PROD_W  = SUM_W + STEP_W;
  localparam int DCNT_W  = $clog2(PROD_W + 1);
  // Quotient seen at least 17 bits wide so saturation can test bit 16 up.
  localparam int QEXT_W  = (PROD_W > 16) ? PROD_W : 17;
  localparam int CMP_W   = (IDX_W > 10) ? IDX_W : 10;
  localparam int SCORE_W = 24;
  localparam int OUT_TDATA_W = 56;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_RANGE    = 3'd0;
  localparam logic [2:0] REG_MAX_RANGE    = 3'd1;
  localparam logic [2:0] REG_MIN_POINTS   = 3'd2;
  localparam logic [2:0] REG_MAX_CLUSTERS = 3'd3;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd4;
  localparam logic [2:0] REG_TARGET_ANGLE = 3'd5;
  localparam logic [2:0] REG_ANGLE_WEIGHT = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_CLUSTER = 2'd0;
  localparam logic [1:0] KIND_BEST    = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOSE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_ERR,
    S_SCORE,
    S_CMP,
    S_EMIT,
    S_AFTER,
    S_BEST
  } lrcs_state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [IDX_W-1:0]  divisor;
  } lrcs_div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } lrcs_div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/lrcs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrcs_divider
// Restoring serial divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module lrcs_divider
  import lrcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire lrcs_div_req_t req,
  output lrcs_div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [IDX_W-1:0]  rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [IDX_W-1:0]  divisor_r;
  logic [IDX_W:0]    trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        cnt_r     <= DCNT_W'(PROD_W);
        rem_r     <= '0;
        quo_r     <= req.dividend;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? IDX_W'(trial - {1'b0, divisor_r}) : IDX_W'(trial);
        quo_r <= {quo_r[PROD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== hdl/lidar_range_cluster_segmenter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_range_cluster_segmenter
// Range-gated segmentation of a lidar scan into clusters, with best pick.
// ----------------------------------------------------------------------------
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+----------------------------------------
// in_     | in  | in_tvalid/in_tready  | tdata: distance_mm; tlast: end_of_scan
// out_    | out | out_tvalid/out_tready| tdata: cluster, angle, range, count;
//         |     |                      | tuser: kind; tlast: last
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index: register, cfg_data: value
//
// A valid sample that does not end the scan is taken in S_IDLE, and the block
// stays ready. Closing a dropped run passes S_CLOSE and S_AFTER; a kept one
// passes S_MUL, S_DIVGO, S_DIV (serial divider for the mean angle), S_ERR,
// S_SCORE, S_CMP, S_EMIT. End of scan adds S_BEST and one best/none beat.
// Synchronous active-low reset; no clearing pass. A result waiting in the
// output register does not block the next input beat, only the next result.
// ----------------------------------------------------------------------------
module lidar_range_cluster_segmenter
  import lrcs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [15:0]            in_tdata,   // [15:0] distance_mm
  input  wire logic                   in_tlast,   // end_of_scan
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] cluster_index, [23:8] angle_hundredths, [39:24] range_mm,
  // [49:40] point_count, [55:50] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast,  // last
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);

  // configuration
  logic [15:0]       min_range_r, max_range_r, target_angle_r;
  logic [9:0]        min_points_r;
  logic [7:0]        max_clusters_r, angle_weight_r;
  logic [STEP_W-1:0] angle_step_r;

  // scan and run state
  lrcs_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   sample_idx_r;
  logic               in_run_r;
  logic [15:0]        run_min_r;
  logic [SUM_W-1:0]   run_sum_r;
  logic [IDX_W-1:0]   run_cnt_r;
  logic [7:0]         stored_r;
  logic               eos_r;
  logic               best_found_r;
  logic [SCORE_W-1:0] lead_score_r;
  logic [15:0]        best_ang_r, best_rng_r;
  logic [IDX_W-1:0]   best_cnt_r;
  logic [7:0]         lead_idx_r;

  // shared arithmetic pipeline
  logic [PROD_W-1:0]  prod_r;
  logic [15:0]        ang_r, err_r;
  logic [SCORE_W-1:0] wprod_r;
  logic [SCORE_W-1:0] score;
  logic [QEXT_W-1:0]  q_ext;

  // output register
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [7:0]         out_idx_r;
  logic [15:0]        out_ang_r, out_rng_r;
  logic [9:0]         out_cnt_r;
  logic               out_last_r;

  logic in_fire, sample_ok, keep, slot_free, out_load;
  lrcs_div_req_t div_req;
  lrcs_div_rsp_t div_rsp;

  lrcs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_tready;
  // A cluster or scan summary enters the output register this cycle.
  assign out_load  = ((state_r == S_EMIT) || (state_r == S_BEST)) && slot_free;

  // Gate: index inside the scan, range in (min, max].
  assign sample_ok = (sample_idx_r < IDX_W'(SCAN_POINTS))
                  && (in_tdata > min_range_r) && (in_tdata <= max_range_r);

  // Keep the closing run only if long enough and the scan has room.
  assign keep = in_run_r && (CMP_W'(run_cnt_r) >= CMP_W'(min_points_r))
             && (stored_r < max_clusters_r);

  assign div_req.start    = (state_r == S_DIVGO);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = run_cnt_r;

  assign q_ext = QEXT_W'(div_rsp.quotient);
  assign score = SCORE_W'(run_min_r) + wprod_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && !(sample_ok && !in_tlast)) state_nxt = S_CLOSE;
      end
      S_CLOSE: state_nxt = keep ? S_MUL : S_AFTER;
      S_MUL:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_ERR;
      end
      S_ERR:   state_nxt = S_SCORE;
      S_SCORE: state_nxt = S_CMP;
      S_CMP:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) state_nxt = S_AFTER;
      end
      S_AFTER: state_nxt = eos_r ? S_BEST : S_IDLE;
      S_BEST: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      min_range_r    <= 16'd150;
      max_range_r    <= 16'd3000;
      min_points_r   <= 10'd3;
      max_clusters_r <= 8'd32;
      angle_step_r   <= STEP_W'(36);
      target_angle_r <= 16'd9000;
      angle_weight_r <= 8'd5;
      sample_idx_r   <= '0;
      in_run_r       <= 1'b0;
      run_min_r      <= '0;
      run_sum_r      <= '0;
      run_cnt_r      <= '0;
      stored_r       <= '0;
      eos_r          <= 1'b0;
      best_found_r   <= 1'b0;
      lead_score_r   <= '1;
      best_ang_r     <= '0;
      best_rng_r     <= '0;
      best_cnt_r     <= '0;
      lead_idx_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_RANGE:    min_range_r    <= cfg_data;
          REG_MAX_RANGE:    max_range_r    <= cfg_data;
          REG_MIN_POINTS:   min_points_r   <= cfg_data[9:0];
          REG_MAX_CLUSTERS: max_clusters_r <= cfg_data[7:0];
          REG_ANGLE_STEP:   angle_step_r   <= cfg_data[STEP_W-1:0];
          REG_TARGET_ANGLE: target_angle_r <= cfg_data;
          REG_ANGLE_WEIGHT: angle_weight_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      // Load a new beat when the slot frees; drain it when the far side takes it.
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            eos_r <= in_tlast;
            if (sample_idx_r < IDX_W'(SCAN_POINTS)) sample_idx_r <= sample_idx_r + 1'b1;
            if (sample_ok) begin
              // Open a new run or extend the current one.
              in_run_r <= 1'b1;
              if (!in_run_r) begin
                run_min_r <= in_tdata;
                run_sum_r <= SUM_W'(sample_idx_r);
                run_cnt_r <= IDX_W'(1);
              end else begin
                if (in_tdata < run_min_r) run_min_r <= in_tdata;
                run_sum_r <= run_sum_r + SUM_W'(sample_idx_r);
                run_cnt_r <= run_cnt_r + 1'b1;
              end
            end
          end
        end
        S_CLOSE: begin
          if (!keep) begin
            in_run_r  <= 1'b0;
            run_min_r <= '0;
            run_sum_r <= '0;
            run_cnt_r <= '0;
          end
        end
        S_MUL: prod_r <= PROD_W'(run_sum_r) * PROD_W'(angle_step_r);
        S_DIV: begin
          if (div_rsp.done) begin
            ang_r <= (|q_ext[QEXT_W-1:16]) ? 16'hFFFF : q_ext[15:0];
          end
        end
        S_ERR:   err_r <= (ang_r > target_angle_r) ? ang_r - target_angle_r
                                                   : target_angle_r - ang_r;
        S_SCORE: wprod_r <= SCORE_W'(angle_weight_r) * SCORE_W'(err_r);
        S_CMP: begin
          // Strict compare: the earlier cluster wins a tie.
          if (score < lead_score_r) begin
            lead_score_r <= score;
            best_found_r <= 1'b1;
            best_ang_r   <= ang_r;
            best_rng_r   <= run_min_r;
            best_cnt_r   <= run_cnt_r;
            lead_idx_r   <= stored_r;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_kind_r  <= KIND_CLUSTER;
            out_idx_r   <= stored_r;
            out_ang_r   <= ang_r;
            out_rng_r   <= run_min_r;
            out_cnt_r   <= 10'(run_cnt_r);
            out_last_r  <= !eos_r;
            stored_r    <= stored_r + 1'b1;
            in_run_r    <= 1'b0;
            run_min_r   <= '0;
            run_sum_r   <= '0;
            run_cnt_r   <= '0;
          end
        end
        S_BEST: begin
          if (slot_free) begin
            out_last_r  <= 1'b1;
            if (best_found_r) begin
              out_kind_r <= KIND_BEST;
              out_idx_r  <= lead_idx_r;
              out_ang_r  <= best_ang_r;
              out_rng_r  <= best_rng_r;
              out_cnt_r  <= 10'(best_cnt_r);
            end else begin
              out_kind_r <= KIND_NONE;
              out_idx_r  <= '0;
              out_ang_r  <= '0;
              out_rng_r  <= '0;
              out_cnt_r  <= '0;
            end
            // Return the per-scan index, run, count and best state to reset.
            sample_idx_r <= '0;
            in_run_r     <= 1'b0;
            run_min_r    <= '0;
            run_sum_r    <= '0;
            run_cnt_r    <= '0;
            stored_r     <= '0;
            best_found_r <= 1'b0;
            lead_score_r <= '1;
            best_ang_r   <= '0;
            best_rng_r   <= '0;
            best_cnt_r   <= '0;
            lead_idx_r   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_cnt_r, out_rng_r, out_ang_r, out_idx_r};

`ifndef NO_ASSERTIONS
  // A valid sample that does not end the scan leaves the sequencer in idle the cycle after.
  a_fast_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sample_ok && !in_tlast) |=> (state_r == S_IDLE))
    else $error("valid sample did not return to idle");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider done outside divide wait");

  // A none result carries an all-zero payload.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_NONE) |-> (out_tdata == '0))
    else $error("none result with payload");

  // Scan summaries close the beat group and leave the cluster count cleared.
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_BEST || out_kind_r == KIND_NONE))
      |-> (out_last_r && stored_r == '0))
    else $error("scan summary without last or clear");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lidar range cluster segmenter. Lidar scans go
// in as sample beats. A cycle-free copy of the segmentation, fed from the
// accepted beats, predicts every cluster, best and none result, and each
// result beat is checked field by field against the oldest prediction.
// Both streams stall at random, and the range window, cluster limits and
// scoring registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  import lrcs_pkg::*;

  localparam int ITEM_GOAL   = 1850;     // sample beats to send in all
  localparam int PHASE_ITEMS = 90;       // random sample beats per setting
  localparam int IDLE_PCT    = 36;       // chance of a stall cycle, percent
  localparam int SETTLE      = 64;       // cycles, past the slowest run close
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [15:0] dist_mm;
    logic        eos;
  } sample_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [15:0] angle;
    logic [15:0] rng;
    logic [9:0]  cnt;
    logic        last;
  } cluster_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  lidar_range_cluster_segmenter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the register file, kept in step with every accepted write.
  // --------------------------------------------------------------------------
  logic [15:0] c_min_range = 16'd150;
  logic [15:0] c_max_range = 16'd3000;
  logic [9:0]  c_min_pts   = 10'd3;
  logic [7:0]  c_max_clus  = 8'd32;
  logic [6:0]  c_step      = 7'd36;
  logic [15:0] c_target    = 16'd9000;
  logic [7:0]  c_weight    = 8'd5;

  // --------------------------------------------------------------------------
  // Per-scan segmentation state of the predictor.
  // --------------------------------------------------------------------------
  logic [9:0]  scan_idx   = '0;
  logic        run_open   = 1'b0;
  logic [15:0] run_min    = '0;
  logic [17:0] run_sum    = '0;
  logic [9:0]  run_cnt    = '0;
  logic [7:0]  kept_cnt   = '0;
  logic        best_seen  = 1'b0;
  logic [23:0] top_score  = '1;
  logic [15:0] best_ang   = '0;
  logic [15:0] best_rng   = '0;
  logic [9:0]  best_cnt   = '0;
  logic [7:0]  top_idx    = '0;

  cluster_beat_t cluster_q[$];   // predicted result beats, oldest first
  sample_t       pend_q[$];      // every sample beat queued for sending
  int            acc_cnt = 0;    // sample beats taken by the block
  int            sent_cnt = 0;   // sample beats put on the bus
  int            total_items = 0;
  int            mismatches = 0;
  int            cycles = 0;
  bit            steady = 1'b0;  // no stalls on either side while set
  bit            gen_scan_open = 1'b0;

  task automatic clear_scan_state();
    scan_idx   = '0;
    run_open   = 1'b0;
    run_min    = '0;
    run_sum    = '0;
    run_cnt    = '0;
    kept_cnt   = '0;
    best_seen  = 1'b0;
    top_score  = '1;
    best_ang   = '0;
    best_rng   = '0;
    best_cnt   = '0;
    top_idx    = '0;
  endtask

  // Close the open run; report a cluster if it is long enough and the
  // per-scan limit has room, and let it compete for best of scan.
  function automatic bit close_run(output cluster_beat_t b);
    logic [31:0] quot;
    logic [31:0] err;
    logic [31:0] score;
    logic [15:0] ang;
    bit          kept;
    b = '0;
    kept = run_open && run_cnt >= c_min_pts && kept_cnt < c_max_clus;
    if (kept) begin
      quot  = (32'(run_sum) * 32'(c_step)) / 32'(run_cnt);
      ang   = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
      err   = (ang > c_target) ? 32'(ang - c_target) : 32'(c_target - ang);
      score = 32'(run_min) + 32'(c_weight) * err;
      // strict compare: the earlier cluster keeps a tie
      if (score < 32'(top_score)) begin
        top_score  = score[23:0];
        best_seen  = 1'b1;
        best_ang   = ang;
        best_rng   = run_min;
        best_cnt   = run_cnt;
        top_idx    = kept_cnt;
      end
      b = '{kind: KIND_CLUSTER, idx: kept_cnt, angle: ang, rng: run_min,
            cnt: run_cnt, last: 1'b0};
      kept_cnt++;
    end
    run_open = 1'b0;
    run_min  = '0;
    run_sum  = '0;
    run_cnt  = '0;
    return kept;
  endfunction

  // Advance the segmentation by one accepted sample and queue its results.
  task automatic segment_sample(input logic [15:0] dist_mm, input logic eos);
    cluster_beat_t beats[2];
    cluster_beat_t b;
    int            n;
    bit            in_window;
    n = 0;
    in_window = scan_idx < SCAN_POINTS && dist_mm > c_min_range && dist_mm <= c_max_range;
    if (in_window) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_min  = dist_mm;
        run_sum  = '0;
        run_cnt  = '0;
      end
      if (dist_mm < run_min) run_min = dist_mm;
      run_sum += 18'(scan_idx);
      run_cnt++;
    end else if (close_run(b)) begin
      beats[n] = b;
      n++;
    end
    // the index sticks at scan size; later samples stay out of window
    if (scan_idx < SCAN_POINTS) scan_idx++;
    if (eos) begin
      if (close_run(b)) begin
        beats[n] = b;
        n++;
      end
      if (best_seen) begin
        beats[n] = '{kind: KIND_BEST, idx: top_idx, angle: best_ang, rng: best_rng,
                     cnt: best_cnt, last: 1'b1};
      end else begin
        beats[n] = '{kind: KIND_NONE, idx: '0, angle: '0, rng: '0, cnt: '0,
                     last: 1'b1};
      end
      n++;
      clear_scan_state();
    end else if (n > 0) begin
      beats[n-1].last = 1'b1;
    end
    for (int k = 0; k < n; k++) cluster_q.push_back(beats[k]);
  endtask

  function automatic string show(input cluster_beat_t b);
    return $sformatf("kind=%0d idx=%0d ang=%0d rng=%0d cnt=%0d last=%0d",
                     b.kind, b.idx, b.angle, b.rng, b.cnt, b.last);
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver: present the next queued beat at the falling edge, hold it
  // until it is taken, and stall at random unless the steady stretch is on.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || acc_cnt == sent_cnt) begin
      if (sent_cnt < pend_q.size() && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pend_q[sent_cnt].dist_mm;
        in_tlast  <= pend_q[sent_cnt].eos;
        sent_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Back-pressure on the result stream, changed at the falling edge only.
  always @(negedge clk) begin
    out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats first, so a beat can never be matched with a
  // prediction made from a sample taken at the same edge; then predict.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cluster_beat_t got;
    cluster_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, idx: out_tdata[7:0], angle: out_tdata[23:8],
                rng: out_tdata[39:24], cnt: out_tdata[49:40], last: out_tlast};
        if (cluster_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: %s", $time, show(got));
        end else begin
          want = cluster_q.pop_front();
          if (got !== want || out_tdata[OUT_TDATA_W-1:50] !== '0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result beat differs\n  expected %s pad=0\n  actual   %s pad=%0h",
                       $time, show(want), show(got), out_tdata[OUT_TDATA_W-1:50]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        segment_sample(in_tdata, in_tlast);
        acc_cnt++;
      end
    end
  end

  // Watchdog: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_sample(input logic [15:0] dist_mm, input logic eos);
    pend_q.push_back('{dist_mm: dist_mm, eos: eos});
    gen_scan_open = !eos;
    total_items++;
  endtask

  // Pick a range inside or outside the current window; with an empty window
  // every value is out, so draw from the whole field.
  function automatic logic [15:0] pick_dist(input bit in_window);
    if (c_min_range >= c_max_range) return 16'($urandom_range(65535));
    if (in_window) return 16'($urandom_range(int'(c_max_range), int'(c_min_range) + 1));
    if (c_max_range != 16'hFFFF && $urandom_range(1) == 1)
      return 16'($urandom_range(65535, int'(c_max_range) + 1));
    return 16'($urandom_range(int'(c_min_range), 0));
  endfunction

  // One scan: mostly gaps and runs with lengths around min_points, else
  // noise across the full range, else a broken stretch with stray scan ends.
  task automatic add_scan();
    int mode;
    int segs;
    int len;
    int cap;
    mode = $urandom_range(99);
    if (mode < 80) begin
      segs = $urandom_range(6, 1);
      cap  = (int'(c_min_pts) + 3 > 30) ? 30 : int'(c_min_pts) + 3;
      for (int s = 0; s < segs; s++) begin
        repeat ($urandom_range(3)) push_sample(pick_dist(1'b0), 1'b0);
        repeat ($urandom_range(cap, 1)) push_sample(pick_dist(1'b1), 1'b0);
      end
      push_sample(pick_dist($urandom_range(1)), 1'b1);
    end else if (mode < 92) begin
      len = $urandom_range(30, 1);
      repeat (len - 1) push_sample(16'($urandom_range(65535)), 1'b0);
      push_sample(16'($urandom_range(65535)), 1'b1);
    end else begin
      repeat ($urandom_range(12, 1))
        push_sample(pick_dist($urandom_range(1)), $urandom_range(3) == 0);
    end
  endtask

  // Scan longer than SCAN_POINTS: either solid in-window samples, giving one
  // full-size cluster, or in/out alternating, giving a one-sample run per pair.
  task automatic add_long_scan(input bit alternate);
    int n;
    n = $urandom_range(540, 514);
    for (int k = 0; k < n; k++)
      push_sample(pick_dist(alternate ? (k % 2 == 0) : 1'b1), k == n - 1);
  endtask

  // Wait until every queued beat is taken and every result has come back.
  task automatic drain();
    @(negedge clk);
    while (acc_cnt != pend_q.size() || cluster_q.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_RANGE:    c_min_range = data;
      REG_MAX_RANGE:    c_max_range = data;
      REG_MIN_POINTS:   c_min_pts   = data[9:0];
      REG_MAX_CLUSTERS: c_max_clus  = data[7:0];
      REG_ANGLE_STEP:   c_step      = data[6:0];
      REG_TARGET_ANGLE: c_target    = data;
      REG_ANGLE_WEIGHT: c_weight    = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill the bits above a narrow register with noise; the block must drop them.
  function automatic logic [15:0] with_junk(input int value, input int width);
    logic [15:0] noise;
    noise = 16'($urandom_range(65535));
    if (width < 16) return (noise << width) | 16'(value & ((1 << width) - 1));
    return 16'(value);
  endfunction

  // Let the last dropped run finish, then rewrite the whole register file.
  task automatic set_config(input int min_r, input int max_r, input int min_p,
                            input int max_c, input int step, input int tgt,
                            input int wt);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_write(REG_MIN_RANGE,    with_junk(min_r, 16));
    cfg_write(REG_MAX_RANGE,    with_junk(max_r, 16));
    cfg_write(REG_MIN_POINTS,   with_junk(min_p, 10));
    cfg_write(REG_MAX_CLUSTERS, with_junk(max_c, 8));
    cfg_write(REG_ANGLE_STEP,   with_junk(step, 7));
    cfg_write(REG_TARGET_ANGLE, with_junk(tgt, 16));
    cfg_write(REG_ANGLE_WEIGHT, with_junk(wt, 8));
    cfg_write(REG_SPARE,        16'($urandom_range(65535)));
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    int phase_start;
    int min_r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: window edges (150 out, 151 and 3000 in, 3001 out),
    // a kept run closed by an out-of-window sample, a short run dropped,
    // a run closed by scan end with best pick, then two scans with no cluster.
    push_sample(16'd0, 1'b0);
    push_sample(16'd151, 1'b0);
    push_sample(16'd3000, 1'b0);
    push_sample(16'd200, 1'b0);
    push_sample(16'd3001, 1'b0);
    push_sample(16'd150, 1'b0);
    push_sample(16'd500, 1'b0);
    push_sample(16'd600, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd1000, 1'b1);
    push_sample(16'd0, 1'b1);
    push_sample(16'd2000, 1'b1);

    // Zero angle weight makes equal ranges tie, so the first cluster must win;
    // min_points of zero must act as one, keeping the single-sample run.
    set_config(150, 3000, 0, 32, 36, 9000, 0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd0, 1'b1);

    for (ph = 0; total_items < ITEM_GOAL; ph++) begin
      case (ph)
        // widest window, largest step, weight and cluster limit
        0: set_config(0, 65535, 1, 255, 127, 0, 255);
        // empty window, zero step, no clusters allowed, unreachable points
        1: set_config(65535, 0, 1023, 0, 0, 65535, 0);
        2: set_config(150, 3000, 3, 32, 36, 9000, 5);
        3: set_config(500, 4000, 2, 1, 100, 18000, 1);
        // only a full-scan run is long enough
        4: set_config(100, 60000, 512, 8, 1, 0, 0);
        default: begin
          min_r = $urandom_range(2000);
          set_config(min_r,
                     ($urandom_range(9) == 0) ? $urandom_range(min_r)
                                              : min_r + $urandom_range(6000, 1),
                     $urandom_range(6),
                     ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(255, 4),
                     $urandom_range(127),
                     $urandom_range(20000),
                     $urandom_range(255));
        end
      endcase
      steady = (ph == 3);
      phase_start = total_items;
      if (ph == 0) add_long_scan(1'b1);
      if (ph == 4) add_long_scan(1'b0);
      while (total_items - phase_start < PHASE_ITEMS) begin
        add_scan();
        // open a run mid-scan, then hold the sender until every result is back
        if (ph == 2 && total_items - phase_start > PHASE_ITEMS / 2 && !gen_scan_open) begin
          repeat (3) push_sample(pick_dist(1'b1), 1'b0);
          drain();
        end
      end
      // close any scan left open by a broken stretch
      if (gen_scan_open) push_sample(pick_dist(1'b0), 1'b1);
    end

    drain();
    steady = 1'b0;
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
